// File: sv/cbor_subset_token_decoder_assert.svh
// Assertion macros used by the top-level decoder file.
// All checks sample on the rising edge of clk and are off while rst_n is low.
`ifndef CBOR_SUBSET_TOKEN_DECODER_ASSERT_SVH
`define CBOR_SUBSET_TOKEN_DECODER_ASSERT_SVH

// Same-cycle implication.
`define CBORTD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBORTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cbortd_pkg.sv
package cbortd_pkg;

    localparam int BYTE_W  = 8;
    localparam int ARG_W   = 64;
    localparam int TLEN_W  = 16;
    localparam int CNT_W   = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Head byte info field
    localparam logic [4:0] INFO_ONE_BYTE = 5'd24;
    localparam logic [4:0] INFO_RESERVED = 5'd28;

    // Register reset values
    localparam logic [7:0]        MAP_PAIRS_RESET   = 8'd16;
    localparam logic [7:0]        ARRAY_ITEMS_RESET = 8'd64;
    localparam logic [TLEN_W-1:0] TEXT_CAP_RESET    = 16'd64;

    typedef enum logic [2:0] {
        MAJ_UINT   = 3'd0,
        MAJ_NEGINT = 3'd1,
        MAJ_BYTES  = 3'd2,
        MAJ_TEXT   = 3'd3,
        MAJ_ARRAY  = 3'd4,
        MAJ_MAP    = 3'd5,
        MAJ_TAG    = 3'd6,
        MAJ_SIMPLE = 3'd7
    } major_t;

    typedef enum logic [2:0] {
        K_UINT      = 3'd0,
        K_NEGINT    = 3'd1,
        K_TEXT_HEAD = 3'd2,
        K_TEXT_BYTE = 3'd3,
        K_ARRAY     = 3'd4,
        K_MAP       = 3'd5,
        K_BOOL      = 3'd6,
        K_ERROR     = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE  = 3'd0,
        E_MAJOR = 3'd1,
        E_INFO  = 3'd2,
        E_LIMIT = 3'd3,
        E_TRUNC = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        REG_MAX_MAP   = 2'd0,
        REG_MAX_ARRAY = 2'd1,
        REG_TEXT_CAP  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]        max_map_pairs;
        logic [7:0]        max_array_items;
        logic [TLEN_W-1:0] text_capacity;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_message;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ARG_W-1:0]  argument;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_text_byte;
        err_t              error_code;
    } res_t;

endpackage

// File: sv/cbortd_in_if.sv
interface cbortd_in_if;
    logic                          valid;
    logic                          ready;
    logic [cbortd_pkg::BYTE_W-1:0] in_byte;
    logic                          end_of_message;

    modport source (output valid, in_byte, end_of_message, input ready);
    modport sink   (input valid, in_byte, end_of_message, output ready);
endinterface

// File: sv/cbortd_out_if.sv
interface cbortd_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic [cbortd_pkg::ARG_W-1:0]  argument;
    logic [cbortd_pkg::BYTE_W-1:0] payload_byte;
    logic                          last_text_byte;
    logic [2:0]                    error_code;

    modport source (output valid, kind, argument, payload_byte, last_text_byte, error_code,
                    input ready);
    modport sink   (input valid, kind, argument, payload_byte, last_text_byte, error_code,
                    output ready);
endinterface

// File: sv/cbor_subset_token_decoder.sv
// CBOR item-head decoder: takes one message byte per clock cycle on byte_in and
// gives at most one token per byte on token_out (uint, negint, text head, text
// byte, array, map, bool or error). A byte sits in an input register, is decoded
// against the running head state in one step, and its token lands in an output
// register; with token_out.ready held high the sustained rate is one byte per
// cycle, set by that single decode step. The input side keeps accepting while a
// finished token waits to be taken, and only stalls when both registers are
// full. Limits are set over the APB port: max_map_pairs at 0x0, max_array_items
// at 0x4, text_capacity at 0x8; write them only while no message is in flight.
// After an error the decoder drops bytes up to and including the next
// end-of-message byte.
`include "cbor_subset_token_decoder_assert.svh"

module cbor_subset_token_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    cbortd_in_if.sink                      byte_in,
    cbortd_out_if.source                   token_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbortd_pkg::PADDR_W-1:0] paddr,
    input  logic [cbortd_pkg::PDATA_W-1:0] pwdata,
    output logic [cbortd_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);

    cbortd_pkg::cfg_t  cfg;
    cbortd_pkg::item_t s1_item_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_fire;
    logic              in_fire;

    logic              dec_valid;
    cbortd_pkg::res_t  dec_res;
    cbortd_pkg::res_t  out_res_reg;
    logic              out_valid_reg, out_valid_next;

    cbortd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbortd_head_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    // Handshake: decode moves when the output slot is free or being drained
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || token_out.ready);
    assign byte_in.ready = !s1_valid_reg || s1_fire;
    assign in_fire       = byte_in.valid && byte_in.ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire ? dec_valid : (out_valid_reg && !token_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.in_byte        <= byte_in.in_byte;
            s1_item_reg.end_of_message <= byte_in.end_of_message;
        end
        if (s1_fire && dec_valid)
            out_res_reg <= dec_res;
    end

    assign token_out.valid          = out_valid_reg;
    assign token_out.kind           = out_res_reg.kind;
    assign token_out.argument       = out_res_reg.argument;
    assign token_out.payload_byte   = out_res_reg.payload_byte;
    assign token_out.last_text_byte = out_res_reg.last_text_byte;
    assign token_out.error_code     = out_res_reg.error_code;

    // Input only stalls with both the input and output registers full and blocked
    `CBORTD_ASSERT_IMPLY(a_stall_cause, !byte_in.ready,
        s1_valid_reg && out_valid_reg && !token_out.ready, "input stalled without cause")

    // An accepted byte is held for decode in the next cycle
    `CBORTD_ASSERT_NEXT(a_accept_held, in_fire, s1_valid_reg, "accepted byte lost")

    // A text head always passed the 16-bit capacity check
    `CBORTD_ASSERT_IMPLY(a_text_len,
        token_out.valid && token_out.kind == cbortd_pkg::K_TEXT_HEAD,
        token_out.argument[cbortd_pkg::ARG_W-1:cbortd_pkg::TLEN_W] == '0,
        "text head length beyond capacity range")

endmodule

// File: sv/cbortd_cfg_regs.sv
module cbortd_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbortd_pkg::PADDR_W-1:0]     paddr,
    input  logic [cbortd_pkg::PDATA_W-1:0]     pwdata,
    output logic [cbortd_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    output cbortd_pkg::cfg_t                   cfg
);

    cbortd_pkg::cfg_t     cfg_reg;
    cbortd_pkg::cfg_t     cfg_next;
    cbortd_pkg::reg_idx_t idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = cbortd_pkg::reg_idx_t'(paddr[cbortd_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                cbortd_pkg::REG_MAX_MAP:   cfg_next.max_map_pairs   = pwdata[7:0];
                cbortd_pkg::REG_MAX_ARRAY: cfg_next.max_array_items = pwdata[7:0];
                cbortd_pkg::REG_TEXT_CAP:
                    cfg_next.text_capacity = pwdata[cbortd_pkg::TLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_map_pairs   <= cbortd_pkg::MAP_PAIRS_RESET;
            cfg_reg.max_array_items <= cbortd_pkg::ARRAY_ITEMS_RESET;
            cfg_reg.text_capacity   <= cbortd_pkg::TEXT_CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            cbortd_pkg::REG_MAX_MAP:
                prdata = cbortd_pkg::PDATA_W'(cfg_reg.max_map_pairs);
            cbortd_pkg::REG_MAX_ARRAY:
                prdata = cbortd_pkg::PDATA_W'(cfg_reg.max_array_items);
            cbortd_pkg::REG_TEXT_CAP:
                prdata = cbortd_pkg::PDATA_W'(cfg_reg.text_capacity);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/cbortd_head_decode.sv
module cbortd_head_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  cbortd_pkg::item_t  item,
    input  cbortd_pkg::cfg_t   cfg,
    output logic               res_valid,
    output cbortd_pkg::res_t   res
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ARG  = 2'd1,
        PH_TEXT = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    localparam int ARG_W = cbortd_pkg::ARG_W;
    localparam int BYTE_W = cbortd_pkg::BYTE_W;

    phase_t                          phase_reg, phase_next;
    cbortd_pkg::major_t              major_reg, major_next;
    logic [cbortd_pkg::CNT_W-1:0]    left_reg, left_next;
    logic [ARG_W-1:0]                acc_reg, acc_next;
    logic [cbortd_pkg::TLEN_W-1:0]   text_reg, text_next;

    logic [BYTE_W-1:0]               b;
    logic                            eom;
    cbortd_pkg::major_t              major;
    logic [4:0]                      info;
    logic [ARG_W-1:0]                acc_shift;

    cbortd_pkg::major_t              fin_major;
    logic [ARG_W-1:0]                fin_v;
    cbortd_pkg::kind_t               fin_kind;
    cbortd_pkg::err_t                fin_err;
    logic                            fin_to_text;

    logic                            do_fin;
    logic                            do_fail;
    cbortd_pkg::err_t                fail_err;

    assign b         = item.in_byte;
    assign eom       = item.end_of_message;
    assign major     = cbortd_pkg::major_t'(b[7:5]);
    assign info      = b[4:0];
    assign acc_shift = {acc_reg[ARG_W-BYTE_W-1:0], b};

    // Argument source: inline info or the completed big-endian accumulator
    assign fin_major = (phase_reg == PH_ARG) ? major_reg : major;
    assign fin_v     = (phase_reg == PH_ARG) ? acc_shift : ARG_W'(info);

    // Head completion: token kind, limit and truncation checks
    always_comb
    begin
        fin_kind    = cbortd_pkg::K_UINT;
        fin_err     = cbortd_pkg::E_NONE;
        fin_to_text = 1'b0;
        case (fin_major)
            cbortd_pkg::MAJ_UINT:
                fin_kind = cbortd_pkg::K_UINT;
            cbortd_pkg::MAJ_NEGINT:
            begin
                fin_kind = cbortd_pkg::K_NEGINT;
                if (fin_v[ARG_W-1])
                    fin_err = cbortd_pkg::E_LIMIT;
            end
            cbortd_pkg::MAJ_TEXT:
            begin
                fin_kind = cbortd_pkg::K_TEXT_HEAD;
                if (fin_v >= ARG_W'(cfg.text_capacity))
                    fin_err = cbortd_pkg::E_LIMIT;
                else if (fin_v != '0)
                begin
                    if (eom)
                        fin_err = cbortd_pkg::E_TRUNC;
                    else
                        fin_to_text = 1'b1;
                end
            end
            cbortd_pkg::MAJ_ARRAY:
            begin
                fin_kind = cbortd_pkg::K_ARRAY;
                if (fin_v > ARG_W'(cfg.max_array_items))
                    fin_err = cbortd_pkg::E_LIMIT;
            end
            cbortd_pkg::MAJ_MAP:
            begin
                fin_kind = cbortd_pkg::K_MAP;
                if (fin_v > ARG_W'(cfg.max_map_pairs))
                    fin_err = cbortd_pkg::E_LIMIT;
            end
            cbortd_pkg::MAJ_SIMPLE:
            begin
                fin_kind = cbortd_pkg::K_BOOL;
                if (fin_v > ARG_W'(1))
                    fin_err = cbortd_pkg::E_LIMIT;
            end
            default:
                fin_err = cbortd_pkg::E_MAJOR;
        endcase
    end

    // Per-byte step
    always_comb
    begin
        phase_next = phase_reg;
        major_next = major_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        text_next  = text_reg;
        res_valid  = 1'b0;
        res        = '0;
        do_fin     = 1'b0;
        do_fail    = 1'b0;
        fail_err   = cbortd_pkg::E_NONE;

        case (phase_reg)
            PH_IDLE:
            begin
                if (info >= cbortd_pkg::INFO_RESERVED)
                begin
                    do_fail  = 1'b1;
                    fail_err = cbortd_pkg::E_INFO;
                end
                else if (major == cbortd_pkg::MAJ_BYTES || major == cbortd_pkg::MAJ_TAG)
                begin
                    do_fail  = 1'b1;
                    fail_err = cbortd_pkg::E_MAJOR;
                end
                else
                begin
                    major_next = major;
                    if (info < cbortd_pkg::INFO_ONE_BYTE)
                        do_fin = 1'b1;
                    else if (eom)
                    begin
                        do_fail  = 1'b1;
                        fail_err = cbortd_pkg::E_TRUNC;
                    end
                    else
                    begin
                        left_next  = cbortd_pkg::CNT_W'(1) << info[1:0];
                        acc_next   = '0;
                        phase_next = PH_ARG;
                    end
                end
            end
            PH_ARG:
            begin
                acc_next  = acc_shift;
                left_next = left_reg - cbortd_pkg::CNT_W'(1);
                if (left_reg == cbortd_pkg::CNT_W'(1))
                    do_fin = 1'b1;
                else if (eom)
                begin
                    do_fail  = 1'b1;
                    fail_err = cbortd_pkg::E_TRUNC;
                end
            end
            PH_TEXT:
            begin
                text_next        = text_reg - cbortd_pkg::TLEN_W'(1);
                res_valid        = 1'b1;
                res.kind         = cbortd_pkg::K_TEXT_BYTE;
                res.payload_byte = b;
                if (text_reg == cbortd_pkg::TLEN_W'(1))
                begin
                    res.last_text_byte = 1'b1;
                    phase_next         = PH_IDLE;
                end
                else if (eom)
                begin
                    // truncated payload still carries the byte
                    res.kind       = cbortd_pkg::K_ERROR;
                    res.error_code = cbortd_pkg::E_TRUNC;
                    phase_next     = PH_IDLE;
                end
            end
            default:
            begin
                if (eom)
                    phase_next = PH_IDLE;
            end
        endcase

        if (do_fin)
        begin
            res_valid = 1'b1;
            if (fin_err != cbortd_pkg::E_NONE)
            begin
                res.kind       = cbortd_pkg::K_ERROR;
                res.error_code = fin_err;
                phase_next     = eom ? PH_IDLE : PH_SKIP;
            end
            else
            begin
                res.kind     = fin_kind;
                res.argument = fin_v;
                if (fin_to_text)
                begin
                    phase_next = PH_TEXT;
                    text_next  = fin_v[cbortd_pkg::TLEN_W-1:0];
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end

        if (do_fail)
        begin
            res_valid      = 1'b1;
            res.kind       = cbortd_pkg::K_ERROR;
            res.error_code = fail_err;
            phase_next     = eom ? PH_IDLE : PH_SKIP;
        end
    end

    // Decoder state, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            major_reg <= cbortd_pkg::MAJ_UINT;
            left_reg  <= '0;
            acc_reg   <= '0;
            text_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            major_reg <= major_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            text_reg  <= text_next;
        end
    end

endmodule
